// ----- sv/slpg_pkg.sv -----
`default_nettype none
package slpg_pkg;

  // fixed field widths
  localparam int PERIOD_W   = 16;
  localparam int DUR_W      = 24;
  localparam int PAT_W      = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  // pulse coefficient, Q30 with room for exactly one
  localparam int Q_FRAC = 30;
  localparam int COEF_W = Q_FRAC + 1;

  // parameter defaults
  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int COLOUR_BITS_DEF      = 8;

  localparam logic [PERIOD_W-1:0] BASE_PERIOD_RST = 16'd1000;
  localparam logic [PERIOD_W-1:0] OVR_PERIOD_RST  = 16'd1;

  // odd Taylor terms of sin(u*pi/2), Q30
  localparam logic [63:0] SIN_A1 = 64'd1686629713;
  localparam logic [63:0] SIN_A3 = 64'd693598669;
  localparam logic [63:0] SIN_A5 = 64'd85569306;
  localparam logic [63:0] SIN_A7 = 64'd5026995;
  localparam logic [63:0] SIN_A9 = 64'd172272;

  // one lane per color channel
  localparam int NUM_LANES = 3;
  localparam int LANE_W    = 2;

  typedef enum logic [PAT_W-1:0] {
    PAT_SOLID = 2'd0,
    PAT_FLASH = 2'd1,
    PAT_PULSE = 2'd2,
    PAT_BLANK = 2'd3
  } pat_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ENABLED     = 3'd0,
    CFG_BASE_RED    = 3'd1,
    CFG_BASE_GREEN  = 3'd2,
    CFG_BASE_BLUE   = 3'd3,
    CFG_BASE_PATTERN = 3'd4,
    CFG_BASE_PERIOD = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_MOD_WAIT,
    ST_EVAL,
    ST_IDX_WAIT,
    ST_MUL,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic              accept;
    logic              adv_step;
    logic              mod_start;
    logic              mod_finish;
    logic              idx_start;
    logic              rom_rd;
    logic              mul_en;
    logic [LANE_W-1:0] mul_lane;
    logic              res_plain;
    logic              out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic adv;
    logic phase_lt_per;
    logic div_busy;
    logic pulse;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/slpg_div.sv -----
`default_nettype none
module slpg_div #(
  parameter int DW = slpg_pkg::PERIOD_W + 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [slpg_pkg::PERIOD_W-1:0] divisor,
  input  logic [$clog2(DW+1)-1:0]       steps,
  output logic                          busy,
  output logic [DW-1:0]                 quotient,
  output logic [slpg_pkg::PERIOD_W-1:0] remainder
);
  import slpg_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0]       dvd_r, dvd_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] dsr_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [PERIOD_W:0]   trial;
  logic                ge;

  // restoring step: one quotient bit per cycle, shifted into the dividend word
  always_comb begin
    trial    = {rem_r, dvd_r[DW-1]};
    ge       = (trial >= {1'b0, dsr_r});
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? PERIOD_W'(trial - {1'b0, dsr_r}) : trial[PERIOD_W-1:0];
      dvd_nxt  = {dvd_r[DW-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      busy_nxt = (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy      = busy_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ----- sv/slpg_dp.sv -----
`default_nettype none
module slpg_dp #(
  parameter int SINE_TABLE_DEPTH = slpg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int COLOUR_BITS      = slpg_pkg::COLOUR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  slpg_pkg::ctrl_cmd_t             cmd,
  output slpg_pkg::dp_stat_t              stat,
  input  logic                            cfg_we,
  input  logic [slpg_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [slpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_mode,
  input  logic [COLOUR_BITS-1:0]          in_red,
  input  logic [COLOUR_BITS-1:0]          in_green,
  input  logic [COLOUR_BITS-1:0]          in_blue,
  input  logic [slpg_pkg::PAT_W-1:0]      in_pattern,
  input  logic [slpg_pkg::PERIOD_W-1:0]   in_period_ms,
  input  logic [slpg_pkg::DUR_W-1:0]      in_duration_ms,
  output logic [COLOUR_BITS-1:0]          out_led_red,
  output logic [COLOUR_BITS-1:0]          out_led_green,
  output logic [COLOUR_BITS-1:0]          out_led_blue,
  output logic                            out_indicating
);
  import slpg_pkg::*;

  localparam int CB     = COLOUR_BITS;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int DW     = PERIOD_W + IDX_W;
  localparam int CW     = $clog2(DW + 1);
  localparam int PROD_W = CB + COEF_W;
  localparam int P3_W   = PERIOD_W + 2;

  // pulse coefficient for one table entry, worked out at elaboration
  function automatic logic [COEF_W-1:0] sine_coef(input int idx);
    logic [63:0] one;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] mag;
    one = 64'd1 << Q_FRAC;
    q   = (64'(idx) * 64'd4) / 64'(SINE_TABLE_DEPTH);
    r   = 64'(idx) * 64'd4 - q * 64'(SINE_TABLE_DEPTH);
    u   = (r << Q_FRAC) / 64'(SINE_TABLE_DEPTH);
    if (q[0]) begin
      u = one - u;
    end
    u2  = (u * u) >> Q_FRAC;
    t   = SIN_A9;
    t   = SIN_A7 - ((u2 * t) >> Q_FRAC);
    t   = SIN_A5 - ((u2 * t) >> Q_FRAC);
    t   = SIN_A3 - ((u2 * t) >> Q_FRAC);
    t   = SIN_A1 - ((u2 * t) >> Q_FRAC);
    mag = (u * t) >> Q_FRAC;
    if (mag > one) begin
      mag = one;
    end
    if (q < 64'd2) begin
      return COEF_W'((one + mag) >> 1);
    end
    return COEF_W'((one - mag) >> 1);
  endfunction

  // a period of zero counts as one
  function automatic logic [PERIOD_W-1:0] eff_per(input logic [PERIOD_W-1:0] p);
    return (p == '0) ? PERIOD_W'(1) : p;
  endfunction

  // sine trough: floor(3p/4)
  function automatic logic [PERIOD_W-1:0] trough_of(input logic [PERIOD_W-1:0] p);
    logic [P3_W-1:0] p3;
    p3 = P3_W'(p) * P3_W'(3);
    return p3[P3_W-1:2];
  endfunction

  // v+1, wrapped to zero at the period
  function automatic logic [PERIOD_W-1:0] wrap_inc(input logic [PERIOD_W-1:0] v,
                                                   input logic [PERIOD_W-1:0] per);
    logic [PERIOD_W:0] s;
    s = {1'b0, v} + (PERIOD_W+1)'(1);
    return (s == {1'b0, per}) ? '0 : s[PERIOD_W-1:0];
  endfunction

  // configuration registers
  logic                enabled_r;
  logic [CB-1:0]       base_col_r [NUM_LANES];
  logic [PAT_W-1:0]    base_pat_r;
  logic [PERIOD_W-1:0] base_per_r;

  // pattern state
  logic [PERIOD_W-1:0] phase_r;
  logic                active_r;
  logic [CB-1:0]       ovr_col_r [NUM_LANES];
  logic [PAT_W-1:0]    ovr_pat_r;
  logic [PERIOD_W-1:0] ovr_per_r;
  logic [DUR_W-1:0]    remain_r;
  logic                adv_r;

  // payload
  logic [COEF_W-1:0]   coef_r;
  logic [CB-1:0]       res_r [NUM_LANES];
  logic [CB-1:0]       out_col_r [NUM_LANES];
  logic                out_ind_r;

  logic [COEF_W-1:0]   sine_rom [SINE_TABLE_DEPTH];

  logic [PERIOD_W-1:0] cur_per;
  pat_t                sel_pat;
  logic [CB-1:0]       sel_col [NUM_LANES];
  logic [CB-1:0]       plain_col [NUM_LANES];
  logic [P3_W-1:0]     p4;
  logic [P3_W-1:0]     per3;
  logic                flash_on;
  logic                show;
  logic [PROD_W-1:0]   prod;

  logic                div_start;
  logic [DW-1:0]       div_dvd;
  logic [CW-1:0]       div_steps;
  logic                div_busy;
  logic [DW-1:0]       div_quo;
  logic [PERIOD_W-1:0] div_rem;

  // coefficient table
  for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
    assign sine_rom[gi] = sine_coef(gi);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= 1'b0;
      base_pat_r <= PAT_SOLID;
      base_per_r <= BASE_PERIOD_RST;
      for (int k = 0; k < NUM_LANES; k++) begin
        base_col_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:      enabled_r     <= cfg_wdata[0];
        CFG_BASE_RED:     base_col_r[0] <= cfg_wdata[CB-1:0];
        CFG_BASE_GREEN:   base_col_r[1] <= cfg_wdata[CB-1:0];
        CFG_BASE_BLUE:    base_col_r[2] <= cfg_wdata[CB-1:0];
        CFG_BASE_PATTERN: base_pat_r    <= cfg_wdata[PAT_W-1:0];
        CFG_BASE_PERIOD:  base_per_r    <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // active selection
  always_comb begin
    cur_per = active_r ? eff_per(ovr_per_r) : eff_per(base_per_r);
    sel_pat = pat_t'(active_r ? ovr_pat_r : base_pat_r);
    for (int k = 0; k < NUM_LANES; k++) begin
      sel_col[k] = active_r ? ovr_col_r[k] : base_col_r[k];
    end
  end

  // flash window and plain color
  always_comb begin
    p4       = {phase_r, 2'b00};
    per3     = P3_W'(cur_per) * P3_W'(3);
    flash_on = (p4 < P3_W'(cur_per)) || (p4 > per3);
    show     = enabled_r && ((sel_pat == PAT_SOLID) || ((sel_pat == PAT_FLASH) && flash_on));
    for (int k = 0; k < NUM_LANES; k++) begin
      plain_col[k] = show ? sel_col[k] : '0;
    end
  end

  // override and phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      active_r  <= 1'b0;
      ovr_pat_r <= PAT_SOLID;
      ovr_per_r <= OVR_PERIOD_RST;
      remain_r  <= '0;
      adv_r     <= 1'b0;
      for (int k = 0; k < NUM_LANES; k++) begin
        ovr_col_r[k] <= '0;
      end
    end else if (cmd.accept) begin
      if (in_mode) begin
        active_r     <= 1'b1;
        ovr_col_r[0] <= in_red;
        ovr_col_r[1] <= in_green;
        ovr_col_r[2] <= in_blue;
        ovr_pat_r    <= in_pattern;
        ovr_per_r    <= in_period_ms;
        remain_r     <= in_duration_ms;
        phase_r      <= trough_of(eff_per(in_period_ms));
        adv_r        <= 1'b0;
      end else if (active_r && (remain_r <= DUR_W'(1))) begin
        // override expires: back to base at its trough
        active_r <= 1'b0;
        remain_r <= '0;
        phase_r  <= trough_of(eff_per(base_per_r));
        adv_r    <= 1'b0;
      end else begin
        if (active_r) begin
          remain_r <= remain_r - DUR_W'(1);
        end
        adv_r <= 1'b1;
      end
    end else if (cmd.adv_step) begin
      phase_r <= wrap_inc(phase_r, cur_per);
    end else if (cmd.mod_finish) begin
      phase_r <= wrap_inc(div_rem, cur_per);
    end
  end

  // shared divider: phase mod period, then table index
  always_comb begin
    div_start = cmd.mod_start || cmd.idx_start;
    if (cmd.mod_start) begin
      div_dvd   = {phase_r, {IDX_W{1'b0}}};
      div_steps = CW'(PERIOD_W);
    end else begin
      div_dvd   = DW'(phase_r) * DW'(SINE_TABLE_DEPTH);
      div_steps = CW'(DW);
    end
  end

  slpg_div #(
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (cur_per),
    .steps     (div_steps),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // one channel through the multiplier per cycle
  assign prod = PROD_W'(sel_col[cmd.mul_lane]) * PROD_W'(coef_r);

  always_ff @(posedge clk) begin
    if (cmd.rom_rd) begin
      coef_r <= sine_rom[div_quo[IDX_W-1:0]];
    end
    if (cmd.mul_en) begin
      res_r[cmd.mul_lane] <= prod[Q_FRAC +: CB];
    end
    if (cmd.res_plain) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        res_r[k] <= plain_col[k];
      end
    end
    if (cmd.out_load) begin
      for (int k = 0; k < NUM_LANES; k++) begin
        out_col_r[k] <= res_r[k];
      end
      out_ind_r <= active_r;
    end
  end

  always_comb begin
    stat.adv          = adv_r;
    stat.phase_lt_per = (phase_r < cur_per);
    stat.div_busy     = div_busy;
    stat.pulse        = enabled_r && (sel_pat == PAT_PULSE);
  end

  assign out_led_red    = out_col_r[0];
  assign out_led_green  = out_col_r[1];
  assign out_led_blue   = out_col_r[2];
  assign out_indicating = out_ind_r;

  // phase steps and table reads only use a divider that has finished
  a_adv_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.adv_step || cmd.mod_finish || cmd.rom_rd) |-> !div_busy)
    else $error("phase or index taken while divider busy");

endmodule
`default_nettype wire

// ----- sv/slpg_ctrl.sv -----
`default_nettype none
module slpg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output slpg_pkg::ctrl_cmd_t cmd,
  input  slpg_pkg::dp_stat_t  stat
);
  import slpg_pkg::*;

  state_t            state_r, state_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequencer
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    lane_nxt  = lane_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_ADV;
        end
      end
      ST_ADV: begin
        if (!stat.adv) begin
          state_nxt = ST_EVAL;
        end else if (stat.phase_lt_per) begin
          cmd.adv_step = 1'b1;
          state_nxt    = ST_EVAL;
        end else begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_MOD_WAIT;
        end
      end
      ST_MOD_WAIT: begin
        if (!stat.div_busy) begin
          cmd.mod_finish = 1'b1;
          state_nxt      = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.pulse) begin
          cmd.idx_start = 1'b1;
          state_nxt     = ST_IDX_WAIT;
        end else begin
          cmd.res_plain = 1'b1;
          state_nxt     = ST_DONE;
        end
      end
      ST_IDX_WAIT: begin
        if (!stat.div_busy) begin
          cmd.rom_rd = 1'b1;
          lane_nxt   = '0;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_lane = lane_r;
        if (lane_r == LANE_W'(NUM_LANES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          lane_nxt = lane_r + LANE_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("pending output word overwritten");

  a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mod_start || cmd.idx_start) |-> !stat.div_busy)
    else $error("divider restarted while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall)
    else $error("second word taken while one is in work");

endmodule
`default_nettype wire

// ----- sv/status_led_pattern_generator_unit.sv -----
// Status LED pattern generator: drives one RGB LED from a base color,
// pattern (solid, flash, pulse, blank) and period, or a timed indication.
// Input channel (in_valid / in_stall): in_mode 0 is a one millisecond tick,
// in_mode 1 starts an indication with the color, pattern, period and
// duration fields. Every input word yields exactly one output word
// (out_valid / out_stall) with the LED levels and the indicating flag.
// Config port: cfg_we writes cfg_wdata into register cfg_index (0 enable,
// 1..3 base color, 4 base pattern, 5 base period); write only when idle.
// One word is in work at a time. After accept, a tick advances the phase
// unless it ends an indication, first reducing the phase modulo the period
// by a serial divide when it is not below the period. An enabled pulse
// then runs a bit-serial index divide over DW = 16 + clog2(SINE_TABLE_DEPTH)
// quotient bits, a table read and the three channels through the
// multiplier; other patterns take the plain color. The result is then
// loaded, and a new word can be taken in the cycle after that load.
// The output register holds a finished word while the receiver stalls;
// the next input word is still taken and runs up to its final load.
// Synchronous reset clears the phase, the override and config registers
// (base period 1000 ms, output disabled); out_valid drops.
`default_nettype none
module status_led_pattern_generator_unit #(
  parameter int SINE_TABLE_DEPTH = slpg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int COLOUR_BITS      = slpg_pkg::COLOUR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [COLOUR_BITS-1:0]          in_red,
  input  logic [COLOUR_BITS-1:0]          in_green,
  input  logic [COLOUR_BITS-1:0]          in_blue,
  input  logic [slpg_pkg::PAT_W-1:0]      in_pattern,
  input  logic [slpg_pkg::PERIOD_W-1:0]   in_period_ms,
  input  logic [slpg_pkg::DUR_W-1:0]      in_duration_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [COLOUR_BITS-1:0]          out_led_red,
  output logic [COLOUR_BITS-1:0]          out_led_green,
  output logic [COLOUR_BITS-1:0]          out_led_blue,
  output logic                            out_indicating,
  input  logic                            cfg_we,
  input  logic [slpg_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [slpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import slpg_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  slpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  slpg_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .COLOUR_BITS      (COLOUR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_mode        (in_mode),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_pattern     (in_pattern),
    .in_period_ms   (in_period_ms),
    .in_duration_ms (in_duration_ms),
    .out_led_red    (out_led_red),
    .out_led_green  (out_led_green),
    .out_led_blue   (out_led_blue),
    .out_indicating (out_indicating)
  );

endmodule
`default_nettype wire
